@@ sv/cfd_pkg.sv @@
// Shared types, constants and a function for the command frame deframer.
package cfd_pkg;

    localparam int MAX_PAYLOAD_DEF = 6;
    localparam int PAYLOAD_BYTES   = 6;
    localparam int PAYLOAD_W       = 8 * PAYLOAD_BYTES;

    localparam logic [7:0] HDR_FIRST_RST  = 8'd36;
    localparam logic [7:0] HDR_SECOND_RST = 8'd83;
    localparam logic [7:0] HDR_THIRD_RST  = 8'd62;

    localparam logic [7:0] CMD_LAST     = 8'd11;
    localparam logic [7:0] CMD_INFO_ON  = 8'd8;
    localparam logic [7:0] CMD_INFO_OFF = 8'd9;
    localparam logic [7:0] CMD_IMU_ON   = 8'd10;
    localparam logic [7:0] CMD_IMU_OFF  = 8'd11;

    typedef enum logic [2:0] {
        PH_HDR0,
        PH_HDR1,
        PH_HDR2,
        PH_CMD,
        PH_LEN,
        PH_DATA,
        PH_SUM
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_CSUM    = 3'd1,
        ST_LENGTH  = 3'd2,
        ST_UNKNOWN = 3'd3,
        ST_TIMEOUT = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        CFG_HDR_FIRST  = 2'd0,
        CFG_HDR_SECOND = 2'd1,
        CFG_HDR_THIRD  = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       gap_timeout;
    } in_item_t;

    typedef struct packed {
        logic [7:0]           frame_command;
        logic [PAYLOAD_W-1:0] frame_payload;
        logic [2:0]           payload_count;
        status_t              frame_status;
        logic                 info_stream_on;
        logic                 imu_stream_on;
    } out_item_t;

    typedef struct packed {
        logic [7:0] first;
        logic [7:0] second;
        logic [7:0] third;
    } hdr_cfg_t;

    function automatic logic [7:0] fixed_len(input logic [3:0] code);
        logic [7:0] len;
        unique case (code)
            4'd0:    len = 8'd6;
            4'd2:    len = 8'd2;
            4'd4:    len = 8'd1;
            4'd6:    len = 8'd6;
            default: len = 8'd0;
        endcase
        return len;
    endfunction

endpackage

@@ sv/cfd_channels_if.sv @@
// Channel interfaces: received bytes, frame results and configuration writes.
interface cfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       gap_timeout;

    modport source (output valid, output rx_byte, output gap_timeout, input ready);
    modport sink   (input valid, input rx_byte, input gap_timeout, output ready);
endinterface

interface cfd_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  frame_command;
    logic [47:0] frame_payload;
    logic [2:0]  payload_count;
    logic [2:0]  frame_status;
    logic        info_stream_on;
    logic        imu_stream_on;

    modport source (output valid, output frame_command, output frame_payload,
                    output payload_count, output frame_status,
                    output info_stream_on, output imu_stream_on, input ready);
    modport sink   (input valid, input frame_command, input frame_payload,
                    input payload_count, input frame_status,
                    input info_stream_on, input imu_stream_on, output ready);
endinterface

interface cfd_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ sv/cfd_parser.sv @@
// Frame parser: header hunt, command/length check, payload capture, checksum.
module cfd_parser #(
    parameter int MAX_PAYLOAD = cfd_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  cfd_pkg::in_item_t   item,
    input  cfd_pkg::hdr_cfg_t   hdr,
    output logic                result_valid,
    output cfd_pkg::out_item_t  result
);
    import cfd_pkg::*;

    localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

    phase_t               phase_reg, phase_next;
    logic [7:0]           cmd_reg, cmd_next;
    logic [7:0]           len_reg, len_next;
    logic [PAYLOAD_W-1:0] pay_reg, pay_next;
    logic [2:0]           cnt_reg, cnt_next;
    logic [7:0]           xor_reg, xor_next;
    logic                 info_reg, info_next;
    logic                 imu_reg, imu_next;

    logic [7:0] b;
    logic       csum_ok;

    assign b       = item.rx_byte;
    assign csum_ok = (b == xor_reg);

    always_comb
    begin
        phase_next   = phase_reg;
        cmd_next     = cmd_reg;
        len_next     = len_reg;
        pay_next     = pay_reg;
        cnt_next     = cnt_reg;
        xor_next     = xor_reg;
        info_next    = info_reg;
        imu_next     = imu_reg;
        result_valid = 1'b0;
        result       = '0;

        if (item_valid)
        begin
            if (item.gap_timeout)
            begin
                phase_next = PH_HDR0;
                if (phase_reg >= PH_CMD)
                begin
                    result_valid         = 1'b1;
                    result.frame_status  = ST_TIMEOUT;
                    result.frame_command = (phase_reg >= PH_LEN) ? cmd_reg : 8'd0;
                    result.frame_payload = (phase_reg >= PH_DATA) ? pay_reg : '0;
                    result.payload_count = (phase_reg >= PH_DATA) ? cnt_reg : 3'd0;
                end
            end
            else
            begin
                unique case (phase_reg)
                    PH_HDR0:
                    begin
                        phase_next = (b == hdr.first) ? PH_HDR1 : PH_HDR0;
                    end
                    PH_HDR1:
                    begin
                        if (b == hdr.second)
                            phase_next = PH_HDR2;
                        else
                            phase_next = (b == hdr.first) ? PH_HDR1 : PH_HDR0;
                    end
                    PH_HDR2:
                    begin
                        if (b == hdr.third)
                            phase_next = PH_CMD;
                        else
                            phase_next = (b == hdr.first) ? PH_HDR1 : PH_HDR0;
                    end
                    PH_CMD:
                    begin
                        cmd_next   = b;
                        xor_next   = b;
                        phase_next = PH_LEN;
                    end
                    PH_LEN:
                    begin
                        len_next = b;
                        xor_next = xor_reg ^ b;
                        if (cmd_reg > CMD_LAST)
                        begin
                            phase_next           = PH_HDR0;
                            result_valid         = 1'b1;
                            result.frame_command = cmd_reg;
                            result.frame_status  = ST_UNKNOWN;
                        end
                        else if (b != fixed_len(cmd_reg[3:0]) || b > MAX_LEN)
                        begin
                            phase_next           = PH_HDR0;
                            result_valid         = 1'b1;
                            result.frame_command = cmd_reg;
                            result.frame_status  = ST_LENGTH;
                        end
                        else
                        begin
                            pay_next   = '0;
                            cnt_next   = 3'd0;
                            phase_next = (b == 8'd0) ? PH_SUM : PH_DATA;
                        end
                    end
                    PH_DATA:
                    begin
                        for (int i = 0; i < PAYLOAD_BYTES; i++)
                        begin
                            if (cnt_reg == 3'(i))
                                pay_next[8*i +: 8] = pay_reg[8*i +: 8] | b;
                        end
                        xor_next = xor_reg ^ b;
                        cnt_next = cnt_reg + 3'd1;
                        if ({5'd0, cnt_next} >= len_reg)
                            phase_next = PH_SUM;
                    end
                    PH_SUM:
                    begin
                        if (csum_ok)
                        begin
                            unique case (cmd_reg)
                                CMD_INFO_ON:  info_next = 1'b1;
                                CMD_INFO_OFF: info_next = 1'b0;
                                CMD_IMU_ON:   imu_next  = 1'b1;
                                CMD_IMU_OFF:  imu_next  = 1'b0;
                                default: ;
                            endcase
                        end
                        phase_next           = PH_HDR0;
                        result_valid         = 1'b1;
                        result.frame_command = cmd_reg;
                        result.frame_payload = pay_reg;
                        result.payload_count = len_reg[2:0];
                        result.frame_status  = csum_ok ? ST_OK : ST_CSUM;
                    end
                    default:
                    begin
                        phase_next = PH_HDR0;
                    end
                endcase
            end
        end

        result.info_stream_on = info_next;
        result.imu_stream_on  = imu_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HDR0;
            cmd_reg   <= 8'd0;
            len_reg   <= 8'd0;
            cnt_reg   <= 3'd0;
            xor_reg   <= 8'd0;
            info_reg  <= 1'b0;
            imu_reg   <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            cmd_reg   <= cmd_next;
            len_reg   <= len_next;
            cnt_reg   <= cnt_next;
            xor_reg   <= xor_next;
            info_reg  <= info_next;
            imu_reg   <= imu_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pay_reg <= pay_next;
    end

    a_result_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> phase_reg == PH_HDR0)
        else $error("parser did not return to header search after a result");

    a_data_below_len: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DATA |-> {5'd0, cnt_reg} < len_reg)
        else $error("payload byte count reached length while still in data phase");

    a_sum_count_match: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_SUM |-> {5'd0, cnt_reg} == len_reg)
        else $error("payload byte count differs from length at checksum");

endmodule

@@ sv/cfd_out_queue.sv @@
// Two-entry output buffer that decouples frame results from the parser.
module cfd_out_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  cfd_pkg::out_item_t push_item,
    output logic               space,
    cfd_out_if.source          frame
);
    import cfd_pkg::*;

    out_item_t head_reg, head_next;
    out_item_t tail_reg, tail_next;
    logic      head_valid_reg, head_valid_next;
    logic      tail_valid_reg, tail_valid_next;
    logic      pop;

    assign pop   = head_valid_reg && frame.ready;
    assign space = !tail_valid_reg;

    always_comb
    begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        head_valid_next = head_valid_reg;
        tail_valid_next = tail_valid_reg;

        if (pop)
        begin
            head_next       = tail_reg;
            head_valid_next = tail_valid_reg;
            tail_valid_next = 1'b0;
        end

        if (push)
        begin
            if (!head_valid_next)
            begin
                head_next       = push_item;
                head_valid_next = 1'b1;
            end
            else
            begin
                tail_next       = push_item;
                tail_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            tail_valid_reg <= 1'b0;
        end
        else
        begin
            head_valid_reg <= head_valid_next;
            tail_valid_reg <= tail_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

    assign frame.valid          = head_valid_reg;
    assign frame.frame_command  = head_reg.frame_command;
    assign frame.frame_payload  = head_reg.frame_payload;
    assign frame.payload_count  = head_reg.payload_count;
    assign frame.frame_status   = head_reg.frame_status;
    assign frame.info_stream_on = head_reg.info_stream_on;
    assign frame.imu_stream_on  = head_reg.imu_stream_on;

    a_tail_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
        tail_valid_reg |-> head_valid_reg)
        else $error("tail entry held without a head entry");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !tail_valid_reg)
        else $error("result pushed into a full buffer");

    a_tail_promotes: assert property (@(posedge clk) disable iff (!rst_n)
        pop && tail_valid_reg |=> head_valid_reg)
        else $error("tail entry lost on pop");

endmodule

@@ sv/command_frame_deframer_top.sv @@
// Command frame deframer top level: header registers, parser and output buffer.
// A frame's result is written into the output buffer when its final byte is taken.
// Throughput: one received byte per cycle; input stalls only when both buffer slots hold
// results that the sink has not taken.
// Reset: header registers return to "$S>", parser to header search, telemetry flags off,
// output buffer empty. No clearing pass; the block is ready the cycle after reset.
module command_frame_deframer_top #(
    parameter int MAX_PAYLOAD = cfd_pkg::MAX_PAYLOAD_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    cfd_in_if.sink     rx,
    cfd_out_if.source  frame,
    cfd_cfg_if.sink    cfg
);
    import cfd_pkg::*;

    hdr_cfg_t  hdr_reg;
    in_item_t  item;
    out_item_t result;
    logic      result_valid;
    logic      space;
    logic      accept;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_reg.first  <= HDR_FIRST_RST;
            hdr_reg.second <= HDR_SECOND_RST;
            hdr_reg.third  <= HDR_THIRD_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                CFG_HDR_FIRST:  hdr_reg.first  <= cfg.data;
                CFG_HDR_SECOND: hdr_reg.second <= cfg.data;
                CFG_HDR_THIRD:  hdr_reg.third  <= cfg.data;
                default:        hdr_reg        <= hdr_reg;
            endcase
        end
    end

    assign rx.ready         = space;
    assign accept           = rx.valid && rx.ready;
    assign item.rx_byte     = rx.rx_byte;
    assign item.gap_timeout = rx.gap_timeout;

    cfd_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (accept),
        .item         (item),
        .hdr          (hdr_reg),
        .result_valid (result_valid),
        .result       (result)
    );

    cfd_out_queue u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept && result_valid),
        .push_item (result),
        .space     (space),
        .frame     (frame)
    );

endmodule
